FILE: hw/rtl/assert_macros.svh
// ============================================================================
// assert_macros.svh
// Assertion macros shared by the RTL; they compile to nothing in synthesis.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/rpr_pkg.sv
// ============================================================================
// rpr_pkg
// Constants, tables and elaboration-time helpers for the pair rotator.
// ============================================================================
package rpr_pkg;

    localparam int HEAD_DIM      = 128;
    localparam int BASE          = 10000;
    localparam int CORDIC_STAGES = 16;
    localparam int PAIRS         = HEAD_DIM / 2;
    localparam int PAIR_AW       = (PAIRS > 1) ? $clog2(PAIRS) : 1;

    localparam int XW       = 16;
    localparam int POS_W    = 16;
    localparam int IDX_W    = 8;
    localparam int GUARD    = 8;
    localparam int DW       = XW + GUARD + 3;
    localparam int ZW       = 32;
    localparam int PHASE_W  = 40;
    localparam int GAIN_W   = 30;
    localparam int PROD_W   = DW + GAIN_W + 1;
    localparam int FRAC_SH  = 30 + GUARD;
    localparam int SAT_W    = PROD_W - FRAC_SH;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 32;

    localparam logic [POS_W-1:0] MAX_POS_RESET = 16'd8192;
    localparam logic [IDX_W:0]   PAIRS_LIM     = (IDX_W + 1)'(PAIRS);
    localparam logic [63:0]      INV_TWO_PI_Q40 = 64'h28BE60DB94;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam int ATAN_ENTRIES = 24;
    typedef logic [ZW-1:0] atan_t [ATAN_ENTRIES];
    localparam atan_t ATAN_TURNS = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41721,     32'd20860,
        32'd10430,     32'd5215,      32'd2607,      32'd1303,
        32'd651,       32'd325,       32'd162,       32'd81
    };

    typedef logic [PHASE_W-1:0] step_rom_t [PAIRS];

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = 64'd0;
        b = 64'h1 << 62;
        while (b > v) b = b >> 2;
        while (b != 64'd0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Base-two logarithm of BASE in Q.32, fraction by repeated squaring.
    function automatic logic [63:0] log2_base_q32();
        logic [63:0] y;
        logic [63:0] frac;
        int n;
        n = 0;
        while (n < 40 && ((64'(BASE) >> (n + 1)) != 64'd0)) n++;
        y = (64'(BASE) << 31) >> n;
        frac = 64'd0;
        for (int j = 0; j < 32; j++)
        begin
            y = (y * y) >> 31;
            if (y >= (64'h1 << 32))
            begin
                frac[31-j] = 1'b1;
                y = y >> 1;
            end
        end
        return (64'(n) << 32) | frac;
    endfunction

    function automatic step_rom_t build_step_rom();
        step_rom_t   rom;
        logic [63:0] roots [33];
        logic [63:0] lg;
        logic [63:0] e;
        logic [63:0] ei;
        logic [63:0] ef;
        logic [63:0] v;
        logic [127:0] prod;
        roots[0] = 64'h1 << 31;
        for (int k = 1; k <= 32; k++)
            roots[k] = isqrt64(roots[k-1] << 32);
        lg = log2_base_q32();
        for (int i = 0; i < PAIRS; i++)
        begin
            e  = (lg * 64'd2 * 64'(i)) / 64'(HEAD_DIM);
            ei = e >> 32;
            ef = e & 64'hFFFF_FFFF;
            v  = 64'h1 << 32;
            for (int k = 1; k <= 32; k++)
                if (ef[32-k])
                    v = (v * roots[k]) >> 32;
            v = (ei < 64'd64) ? (v >> ei) : 64'd0;
            prod = {64'd0, v} * {64'd0, INV_TWO_PI_Q40};
            rom[i] = prod[PHASE_W+31:32];
        end
        return rom;
    endfunction

    // Inverse CORDIC gain in Q30; the reciprocal is a restoring long division.
    function automatic logic [GAIN_W-1:0] inv_gain_q30();
        logic [63:0] g;
        logic [63:0] t;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] quo;
        g = 64'h1 << 30;
        for (int k = 0; k < CORDIC_STAGES && k < ATAN_ENTRIES; k++)
        begin
            t = isqrt64((64'h1 << 60) + (64'h1 << (60 - 2 * k)));
            g = (g * t) >> 30;
        end
        num = (64'h1 << 60) + (g >> 1);
        rem = 64'd0;
        quo = 64'd0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= g)
            begin
                rem = rem - g;
                quo[b] = 1'b1;
            end
        end
        return quo[GAIN_W-1:0];
    endfunction

    function automatic logic [XW-1:0] sat16(input logic signed [SAT_W-1:0] v);
        logic [XW-1:0] res;
        if (v[SAT_W-1:XW-1] == '0 || v[SAT_W-1:XW-1] == '1)
            res = v[XW-1:0];
        else if (v[SAT_W-1])
            res = {1'b1, {(XW-1){1'b0}}};
        else
            res = {1'b0, {(XW-1){1'b1}}};
        return res;
    endfunction

    localparam step_rom_t         PHASE_STEP_ROM = build_step_rom();
    localparam logic [GAIN_W-1:0] INV_GAIN       = inv_gain_q30();

endpackage

FILE: hw/rtl/rotary_position_pair_rotate.sv
// ============================================================================
// rotary_position_pair_rotate
// Rotary position embedding of one activation pair through a pipelined CORDIC.
// ============================================================================
//  Channel   Direction  Payload
//  s_axis    in         x_even, x_odd, pair_index, token_position; odd_tail
//  m_axis    out        y_even, y_odd; position_error
//  cfg       in         max_positions
//
//  One item is accepted per cycle unless the pipeline stalls; the result
//  passes the one-rotation-per-stage CORDIC pipeline to the output register.
//  Reset clears all valid bits and loads max_positions with 8192.
//  The pipeline advances unless its last stage and the output register both
//  hold items that the sink does not take; the whole pipeline freezes during
//  a stall, so bubbles inside it are not closed up.
// ============================================================================
`include "assert_macros.svh"

module rotary_position_pair_rotate
    import rpr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // x_even[15:0], x_odd[31:16], pair_index[39:32], token_position[55:40]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // odd_tail[0]
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // y_even[15:0], y_odd[31:16]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // position_error[0]
    output logic                   m_axis_tuser,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [POS_W-1:0]       cfg_data
);

    logic adv;
    logic [POS_W-1:0] max_positions_reg;

    // Input decode
    logic [XW-1:0]      in_xe;
    logic [XW-1:0]      in_xo;
    logic [IDX_W-1:0]   in_idx;
    logic [POS_W-1:0]   in_pos;
    logic               in_range;
    logic               s1_err_next;
    logic               s1_cord_next;
    logic [XW-1:0]      s1_be_next;
    logic [XW-1:0]      s1_bo_next;
    logic [PHASE_W-1:0] s1_step_next;

    logic               s1_valid_reg;
    logic               s1_err_reg;
    logic               s1_cord_reg;
    logic [XW-1:0]      s1_be_reg;
    logic [XW-1:0]      s1_bo_reg;
    logic [POS_W-1:0]   s1_pos_reg;
    logic [PHASE_W-1:0] s1_step_reg;

    logic [POS_W+PHASE_W-1:0] phase_prod;
    logic               s2_valid_reg;
    logic               s2_err_reg;
    logic               s2_cord_reg;
    logic [XW-1:0]      s2_be_reg;
    logic [XW-1:0]      s2_bo_reg;
    logic [PHASE_W-1:0] s2_phase_reg;

    logic [PHASE_W-1:0]        phase_rnd;
    logic [1:0]                quad;
    logic [PHASE_W-1:0]        resid;
    logic signed [PHASE_W-1:0] z_full;
    logic signed [XW:0]        xe_ext;
    logic signed [XW:0]        xo_ext;
    logic signed [XW:0]        x_rot;
    logic signed [XW:0]        y_rot;

    logic signed [DW-1:0] cx_reg [0:CORDIC_STAGES];
    logic signed [DW-1:0] cy_reg [0:CORDIC_STAGES];
    logic signed [ZW-1:0] cz_reg [0:CORDIC_STAGES-1];
    logic                 cv_reg [0:CORDIC_STAGES];
    logic                 ce_reg [0:CORDIC_STAGES];
    logic                 cc_reg [0:CORDIC_STAGES];
    logic [XW-1:0]        cbe_reg [0:CORDIC_STAGES];
    logic [XW-1:0]        cbo_reg [0:CORDIC_STAGES];

    logic                     g_valid_reg;
    logic                     g_err_reg;
    logic                     g_cord_reg;
    logic [XW-1:0]            g_be_reg;
    logic [XW-1:0]            g_bo_reg;
    logic signed [PROD_W-1:0] g_x_reg;
    logic signed [PROD_W-1:0] g_y_reg;

    logic signed [PROD_W-1:0] rnd_x;
    logic signed [PROD_W-1:0] rnd_y;
    logic [XW-1:0]            out_ye_next;
    logic [XW-1:0]            out_yo_next;

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_err_reg;

    assign adv           = !g_valid_reg || !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_positions_reg <= MAX_POS_RESET;
        else if (cfg_valid)
            max_positions_reg <= cfg_data;
    end

    // Stage 1: limit check, case selection and step lookup.
    always_comb
    begin
        in_xe        = s_axis_tdata[15:0];
        in_xo        = s_axis_tdata[31:16];
        in_idx       = s_axis_tdata[39:32];
        in_pos       = s_axis_tdata[55:40];
        in_range     = {1'b0, in_idx} < PAIRS_LIM;
        s1_err_next  = in_pos >= max_positions_reg;
        s1_cord_next = !s1_err_next && !s_axis_tuser && in_range;
        s1_be_next   = s1_err_next ? '0 : in_xe;
        s1_bo_next   = (s1_err_next || s_axis_tuser) ? '0 : in_xo;
        s1_step_next = in_range ? PHASE_STEP_ROM[in_idx[PAIR_AW-1:0]] : '0;
    end

    // Stage 2: phase = position times step, modulo one turn.
    assign phase_prod = s1_pos_reg * s1_step_reg;

    // Stage 3: quadrant, residual angle and pre-rotation.
    always_comb
    begin
        phase_rnd = s2_phase_reg + (PHASE_W'(1) << (PHASE_W - 3));
        quad      = phase_rnd[PHASE_W-1:PHASE_W-2];
        resid     = s2_phase_reg - {quad, {(PHASE_W-2){1'b0}}};
        z_full    = $signed(resid) + PHASE_W'(128);
        xe_ext    = {s2_be_reg[XW-1], s2_be_reg};
        xo_ext    = {s2_bo_reg[XW-1], s2_bo_reg};
        unique case (quad)
            QUAD_0:
            begin
                x_rot = xe_ext;
                y_rot = xo_ext;
            end
            QUAD_1:
            begin
                x_rot = -xo_ext;
                y_rot = xe_ext;
            end
            QUAD_2:
            begin
                x_rot = -xe_ext;
                y_rot = -xo_ext;
            end
            QUAD_3:
            begin
                x_rot = xo_ext;
                y_rot = -xe_ext;
            end
            default:
            begin
                x_rot = xe_ext;
                y_rot = xo_ext;
            end
        endcase
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            for (int i = 0; i <= CORDIC_STAGES; i++)
                cv_reg[i] <= 1'b0;
            g_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg <= s_axis_tvalid;
                s2_valid_reg <= s1_valid_reg;
                cv_reg[0]    <= s2_valid_reg;
                for (int i = 0; i < CORDIC_STAGES; i++)
                    cv_reg[i+1] <= cv_reg[i];
                g_valid_reg <= cv_reg[CORDIC_STAGES];
            end
            out_valid_reg <= g_valid_reg || (out_valid_reg && !m_axis_tready);
        end
    end

    // Payload of stages 1 to 3 and the side data along the CORDIC.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_err_reg  <= s1_err_next;
            s1_cord_reg <= s1_cord_next;
            s1_be_reg   <= s1_be_next;
            s1_bo_reg   <= s1_bo_next;
            s1_pos_reg  <= in_pos;
            s1_step_reg <= s1_step_next;

            s2_err_reg   <= s1_err_reg;
            s2_cord_reg  <= s1_cord_reg;
            s2_be_reg    <= s1_be_reg;
            s2_bo_reg    <= s1_bo_reg;
            s2_phase_reg <= phase_prod[PHASE_W-1:0];

            ce_reg[0]  <= s2_err_reg;
            cc_reg[0]  <= s2_cord_reg;
            cbe_reg[0] <= s2_be_reg;
            cbo_reg[0] <= s2_bo_reg;
            cx_reg[0]  <= {{(DW-XW-1-GUARD){x_rot[XW]}}, x_rot, {GUARD{1'b0}}};
            cy_reg[0]  <= {{(DW-XW-1-GUARD){y_rot[XW]}}, y_rot, {GUARD{1'b0}}};
            cz_reg[0]  <= z_full[PHASE_W-1:PHASE_W-ZW];

            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                ce_reg[i+1]  <= ce_reg[i];
                cc_reg[i+1]  <= cc_reg[i];
                cbe_reg[i+1] <= cbe_reg[i];
                cbo_reg[i+1] <= cbo_reg[i];
            end
        end
    end

    // CORDIC: one micro-rotation per stage.
    for (genvar gk = 0; gk < CORDIC_STAGES; gk++)
    begin : g_cordic
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic                 rot_pos;

        assign dx      = cy_reg[gk] >>> gk;
        assign dy      = cx_reg[gk] >>> gk;
        assign rot_pos = !cz_reg[gk][ZW-1];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cx_reg[gk+1] <= rot_pos ? cx_reg[gk] - dx : cx_reg[gk] + dx;
                cy_reg[gk+1] <= rot_pos ? cy_reg[gk] + dy : cy_reg[gk] - dy;
            end
        end

        if (gk < CORDIC_STAGES - 1)
        begin : g_angle
            always_ff @(posedge clk)
            begin
                if (adv)
                    cz_reg[gk+1] <= rot_pos ? cz_reg[gk] - $signed(ATAN_TURNS[gk])
                                            : cz_reg[gk] + $signed(ATAN_TURNS[gk]);
            end
        end
    end

    // Gain compensation
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_err_reg  <= ce_reg[CORDIC_STAGES];
            g_cord_reg <= cc_reg[CORDIC_STAGES];
            g_be_reg   <= cbe_reg[CORDIC_STAGES];
            g_bo_reg   <= cbo_reg[CORDIC_STAGES];
            g_x_reg    <= cx_reg[CORDIC_STAGES] * $signed({1'b0, INV_GAIN});
            g_y_reg    <= cy_reg[CORDIC_STAGES] * $signed({1'b0, INV_GAIN});
        end
    end

    // Rounding, saturation and output register
    always_comb
    begin
        rnd_x = g_x_reg + (PROD_W'(1) <<< (FRAC_SH - 1));
        rnd_y = g_y_reg + (PROD_W'(1) <<< (FRAC_SH - 1));
        out_ye_next = g_cord_reg ? sat16(rnd_x[PROD_W-1:FRAC_SH]) : g_be_reg;
        out_yo_next = g_cord_reg ? sat16(rnd_y[PROD_W-1:FRAC_SH]) : g_bo_reg;
    end

    always_ff @(posedge clk)
    begin
        if (g_valid_reg && adv)
        begin
            out_data_reg <= {out_yo_next, out_ye_next};
            out_err_reg  <= g_err_reg;
        end
    end

    `ASSERT_IMPL(a_err_zero_data, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "error item carries nonzero data")
    `ASSERT_IMPL(a_err_no_rotate, g_valid_reg && g_err_reg, !g_cord_reg && g_be_reg == '0 && g_bo_reg == '0, "rejected item routed to rotation")
    `ASSERT_IMPL(a_ready_when_drained, !g_valid_reg, s_axis_tready, "input stalled with empty pipeline end")
    `ASSERT_NEXT(a_end_held, g_valid_reg && !adv, g_valid_reg && $stable(g_x_reg) && $stable(g_err_reg), "stalled pipeline end lost its item")
    `ASSERT_NEXT(a_cfg_written, cfg_valid && cfg_ready, max_positions_reg == $past(cfg_data), "limit register not updated")

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the rotary position pair rotator. A table of
// directed pairs is followed by random pairs under several position limits.
// Typed rows give their result; others are rotated by a bit-exact model
// of the phase table and the CORDIC, and each result is compared with the
// oldest prediction. Both stream sides idle at random, the sink holds off
// once for a long stretch, and one phase runs with no idling at all.
// ============================================================================
module tb_top;
    import rpr_pkg::*;

    typedef struct {
        logic [15:0] x_even;
        logic [15:0] x_odd;
        logic [7:0]  pair_index;
        logic [15:0] token_position;
        logic        odd_tail;
    } pair_in_t;

    typedef struct {
        logic [15:0] y_even;
        logic [15:0] y_odd;
        logic        position_error;
    } rotated_t;

    typedef struct packed {
        logic [15:0] x_even;
        logic [15:0] x_odd;
        logic [7:0]  pair_index;
        logic [15:0] token_position;
        logic        odd_tail;
        logic        typed;
        logic [15:0] y_even;
        logic [15:0] y_odd;
        logic        position_error;
    } pair_row_t;

    localparam logic [15:0] LIMIT_AFTER_RESET = 16'd8192;
    localparam bit [63:0]   STEP_SCALE        = 64'h28BE60DB94;
    localparam bit [63:0]   PHASE_MASK        = 64'hFF_FFFF_FFFF;
    localparam int          ARC_COUNT         = 24;
    localparam int          ROW_COUNT         = 24;
    localparam int          PHASE_COUNT       = 5;
    localparam int          QUIET_PHASE       = 3;

    localparam longint ARC_TURNS [ARC_COUNT] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81
    };

    localparam logic [15:0] PHASE_LIMITS [PHASE_COUNT] = '{
        16'hFFFF, 16'h0001, 16'h0000, 16'h0000, LIMIT_AFTER_RESET
    };
    localparam int PHASE_ITEMS [PHASE_COUNT] = '{220, 60, 30, 150, 140};

    localparam pair_row_t DIRECTED_ROWS [ROW_COUNT] = '{
        '{16'h7FFF, 16'h8000, 8'd64,  16'd0,     1'b0, 1'b1, 16'h7FFF, 16'h8000, 1'b0},
        '{16'h8000, 16'h7FFF, 8'd255, 16'd8191,  1'b0, 1'b1, 16'h8000, 16'h7FFF, 1'b0},
        '{16'h1234, 16'hABCD, 8'd10,  16'd8192,  1'b0, 1'b1, 16'h0000, 16'h0000, 1'b1},
        '{16'h7FFF, 16'h7FFF, 8'd0,   16'hFFFF,  1'b0, 1'b1, 16'h0000, 16'h0000, 1'b1},
        '{16'h4000, 16'hC000, 8'd3,   16'd9000,  1'b1, 1'b1, 16'h0000, 16'h0000, 1'b1},
        '{16'h8000, 16'h1111, 8'd5,   16'd100,   1'b1, 1'b1, 16'h8000, 16'h0000, 1'b0},
        '{16'h7FFF, 16'hFFFF, 8'd200, 16'd3,     1'b1, 1'b1, 16'h7FFF, 16'h0000, 1'b0},
        '{16'h0001, 16'h5555, 8'd255, 16'd8191,  1'b1, 1'b1, 16'h0001, 16'h0000, 1'b0},
        '{16'h1000, 16'h0000, 8'd0,   16'd0,     1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h1000, 16'h0000, 8'd0,   16'd1,     1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h7FFF, 16'h7FFF, 8'd0,   16'd1,     1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h8000, 16'h8000, 8'd0,   16'd1,     1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h7FFF, 16'h8000, 8'd0,   16'd2,     1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h8000, 16'h7FFF, 8'd0,   16'd3,     1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h1000, 16'hF000, 8'd0,   16'd5,     1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h0000, 16'h0000, 8'd17,  16'd4000,  1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'hABCD, 16'h5432, 8'd63,  16'd8191,  1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h7FFF, 16'h0000, 8'd32,  16'd8191,  1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h8000, 16'h0000, 8'd1,   16'd1234,  1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h0400, 16'hFC00, 8'd63,  16'd1,     1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'hFFFF, 16'h0001, 8'd31,  16'd4096,  1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h7FFF, 16'h7FFF, 8'd62,  16'd77,    1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h5A5A, 16'hA5A5, 8'd0,   16'd100,   1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{16'h1000, 16'h0000, 8'd0,   16'd8191,  1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0}
    };

    logic                   clk;
    logic                   rst_n          = 1'b0;
    logic                   s_axis_tvalid  = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata   = '0;
    logic                   s_axis_tuser   = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   cfg_valid      = 1'b0;
    logic                   cfg_ready;
    logic [POS_W-1:0]       cfg_data       = '0;

    bit [39:0]   phase_step [PAIRS];
    longint      inv_gain;
    logic [15:0] max_positions = LIMIT_AFTER_RESET;
    rotated_t    rotations_due [$];
    int          pairs_accepted = 0;
    int          mismatch_count = 0;
    bit          steady = 1'b0;
    int          sink_hold_left = 0;
    bit          sink_hold_done = 1'b0;

    rotary_position_pair_rotate DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    function automatic bit [63:0] floor_sqrt(input bit [63:0] v_in);
        bit [63:0] v = v_in;
        bit [63:0] r = 64'd0;
        bit [63:0] b = 64'h1 << 62;
        while (b > v) b = b >> 2;
        while (b != 64'd0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Turn step per position for each pair, and the inverse CORDIC gain in Q30.
    function automatic void build_rotation_tables();
        bit [63:0]  roots [33];
        bit [63:0]  y;
        bit [63:0]  frac;
        bit [63:0]  lg;
        bit [63:0]  e;
        bit [63:0]  v;
        bit [63:0]  g;
        bit [63:0]  t;
        bit [127:0] wide;
        int         n;
        roots[0] = 64'h1 << 31;
        for (int k = 1; k <= 32; k++)
            roots[k] = floor_sqrt(roots[k-1] << 32);
        n = 0;
        while (n < 40 && ((64'(BASE) >> (n + 1)) != 64'd0)) n++;
        y = (64'(BASE) << 31) >> n;
        frac = 64'd0;
        for (int j = 0; j < 32; j++)
        begin
            y = (y * y) >> 31;
            if (y >= 64'h1_0000_0000)
            begin
                frac[31-j] = 1'b1;
                y = y >> 1;
            end
        end
        lg = (64'(n) << 32) | frac;
        for (int i = 0; i < PAIRS; i++)
        begin
            e = (lg * 64'd2 * 64'(i)) / 64'(HEAD_DIM);
            v = 64'h1 << 32;
            for (int k = 1; k <= 32; k++)
                if (e[32-k])
                    v = (v * roots[k]) >> 32;
            v = ((e >> 32) < 64'd64) ? (v >> (e >> 32)) : 64'd0;
            wide = 128'(v) * 128'(STEP_SCALE);
            phase_step[i] = wide[71:32];
        end
        g = 64'h1 << 30;
        for (int k = 0; k < CORDIC_STAGES && k < ARC_COUNT; k++)
        begin
            t = floor_sqrt((64'h1 << 60) + (64'h1 << (60 - 2 * k)));
            g = (g * t) >> 30;
        end
        inv_gain = longint'(((64'h1 << 60) + g / 2) / g);
    endfunction

    function automatic logic [15:0] clamp_q312(input longint v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    function automatic rotated_t rope_rotate(input pair_in_t p);
        rotated_t  res;
        bit [63:0] phase;
        bit [63:0] q;
        bit [63:0] r;
        longint    resid;
        longint    z;
        longint    x;
        longint    y;
        longint    dx;
        longint    dy;
        res.y_even = 16'h0000;
        res.y_odd = 16'h0000;
        res.position_error = 1'b0;
        if (p.token_position >= max_positions)
        begin
            res.position_error = 1'b1;
            return res;
        end
        if (p.odd_tail)
        begin
            res.y_even = p.x_even;
            return res;
        end
        if (p.pair_index >= PAIRS)
        begin
            res.y_even = p.x_even;
            res.y_odd = p.x_odd;
            return res;
        end
        phase = (64'(p.token_position) * 64'(phase_step[p.pair_index])) & PHASE_MASK;
        q = ((phase + (64'h1 << 37)) >> 38) & 64'd3;
        r = (phase - (q << 38)) & PHASE_MASK;
        resid = r[39] ? longint'(r) - (longint'(1) <<< 40) : longint'(r);
        z = (resid + 128) >>> 8;
        case (q[1:0])
            QUAD_0:
            begin
                x = longint'($signed(p.x_even));
                y = longint'($signed(p.x_odd));
            end
            QUAD_1:
            begin
                x = -longint'($signed(p.x_odd));
                y = longint'($signed(p.x_even));
            end
            QUAD_2:
            begin
                x = -longint'($signed(p.x_even));
                y = -longint'($signed(p.x_odd));
            end
            default:
            begin
                x = longint'($signed(p.x_odd));
                y = -longint'($signed(p.x_even));
            end
        endcase
        x = x <<< GUARD;
        y = y <<< GUARD;
        for (int k = 0; k < CORDIC_STAGES && k < ARC_COUNT; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARC_TURNS[k];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARC_TURNS[k];
            end
        end
        res.y_even = clamp_q312((x * inv_gain + (longint'(1) <<< (29 + GUARD))) >>> (30 + GUARD));
        res.y_odd = clamp_q312((y * inv_gain + (longint'(1) <<< (29 + GUARD))) >>> (30 + GUARD));
        return res;
    endfunction

    function automatic pair_in_t random_pair(input logic [15:0] limit);
        pair_in_t p;
        p.x_even = 16'($urandom);
        p.x_odd = 16'($urandom);
        if ($urandom_range(9) == 0)
            p.x_even = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        if ($urandom_range(9) == 0)
            p.x_odd = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        if ($urandom_range(3) != 0)
            p.pair_index = 8'($urandom_range(PAIRS - 1));
        else
            p.pair_index = 8'($urandom);
        if (limit != 16'd0 && $urandom_range(99) < 85)
            p.token_position = 16'($urandom_range(32'(limit) - 1));
        else
            p.token_position = 16'($urandom);
        p.odd_tail = ($urandom_range(99) < 8);
        return p;
    endfunction

    function automatic void flag_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    task automatic send_pair(input pair_in_t p, input rotated_t want);
        while (!steady && $urandom_range(99) < 22)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p.token_position, p.pair_index, p.x_odd, p.x_even};
        s_axis_tuser  <= p.odd_tail;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        rotations_due = {rotations_due, want};
        pairs_accepted++;
    endtask

    task automatic write_max_positions(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        max_positions = value;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge clk)
    begin
        rotated_t want;
        rotated_t got;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.y_even = m_axis_tdata[15:0];
                got.y_odd = m_axis_tdata[31:16];
                got.position_error = m_axis_tuser;
                if (rotations_due.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected item, expected none, actual %h/%h/%b",
                             $time, got.y_even, got.y_odd, got.position_error);
                end
                else
                begin
                    want = rotations_due.pop_front();
                    flag_field("y_even", want.y_even, got.y_even);
                    flag_field("y_odd", want.y_odd, got.y_odd);
                    flag_field("position_error", 16'(want.position_error),
                               16'(got.position_error));
                end
            end
            if (!sink_hold_done && pairs_accepted >= 60)
            begin
                sink_hold_left = 200;
                sink_hold_done = 1'b1;
            end
            if (sink_hold_left > 0)
            begin
                sink_hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= steady || ($urandom_range(99) >= 22);
            end
        end
    end

    initial
    begin
        pair_in_t    p;
        rotated_t    want;
        logic [15:0] limit;
        build_rotation_tables();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[i])
        begin
            p.x_even = DIRECTED_ROWS[i].x_even;
            p.x_odd = DIRECTED_ROWS[i].x_odd;
            p.pair_index = DIRECTED_ROWS[i].pair_index;
            p.token_position = DIRECTED_ROWS[i].token_position;
            p.odd_tail = DIRECTED_ROWS[i].odd_tail;
            if (DIRECTED_ROWS[i].typed)
            begin
                want.y_even = DIRECTED_ROWS[i].y_even;
                want.y_odd = DIRECTED_ROWS[i].y_odd;
                want.position_error = DIRECTED_ROWS[i].position_error;
            end
            else
            begin
                want = rope_rotate(p);
            end
            send_pair(p, want);
        end
        s_axis_tvalid <= 1'b0;

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            while (rotations_due.size() != 0) @(posedge clk);
            limit = (ph == QUIET_PHASE) ? 16'($urandom_range(2, 65534)) : PHASE_LIMITS[ph];
            write_max_positions(limit);
            steady = (ph == QUIET_PHASE);
            repeat (PHASE_ITEMS[ph])
            begin
                p = random_pair(max_positions);
                send_pair(p, rope_rotate(p));
            end
            s_axis_tvalid <= 1'b0;
        end

        while (rotations_due.size() != 0) @(posedge clk);
        repeat (CORDIC_STAGES + 8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
